// ----- hw/rtl/grwf_pkg.sv -----
package grwf_pkg;

  // field widths
  localparam int unsigned FW = 16;   // every input and output field
  localparam int unsigned PW = 32;   // quaternion product, Q.28
  localparam int unsigned MW = 34;   // matrix entry and gravity, Q.28
  localparam int unsigned GW = 22;   // rounded gravity, Q.16
  localparam int unsigned LW = 24;   // linear acceleration, Q.16
  localparam int unsigned XW = MW + LW;  // matrix times linear, Q.44
  localparam int unsigned SW = XW + 2;   // sum of three products
  localparam int unsigned RW = SW - 32;  // rounded world value, Q16.12

  localparam int unsigned G_SHIFT   = 12;
  localparam int unsigned OUT_SHIFT = 32;

  // register stages from input transfer to output register
  localparam int unsigned NSTG = 6;

  localparam int unsigned IN_DATA_W  = 7 * FW;
  localparam int unsigned OUT_DATA_W = 3 * FW;

  typedef logic signed [FW-1:0] field_t;
  typedef logic signed [MW-1:0] ment_t;
  typedef ment_t mat_t [3][3];

  typedef struct packed {
    field_t w;
    field_t x;
    field_t y;
    field_t z;
  } quat_t;

  // saturate a rounded world value to the output range
  function automatic field_t sat_out(input logic signed [RW-1:0] v);
    field_t res;
    if (v > RW'(32767)) begin
      res = 16'sh7fff;
    end else if (v < -RW'(32768)) begin
      res = 16'sh8000;
    end else begin
      res = v[FW-1:0];
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/grwf_quat_matrix.sv -----
module grwf_quat_matrix (
  input  logic           clk,
  input  logic           en,
  input  grwf_pkg::quat_t quat,
  output grwf_pkg::mat_t mat
);
  import grwf_pkg::*;

  logic signed [PW-1:0] ww_r, xx_r, yy_r, zz_r, wx_r, wy_r, wz_r, xy_r, xz_r, yz_r;
  logic signed [PW-1:0] ww_nxt, xx_nxt, yy_nxt, zz_nxt, wx_nxt, wy_nxt, wz_nxt;
  logic signed [PW-1:0] xy_nxt, xz_nxt, yz_nxt;
  mat_t mat_r, mat_nxt;

  // stage one: the ten quaternion products
  always_comb begin
    ww_nxt = quat.w * quat.w;
    xx_nxt = quat.x * quat.x;
    yy_nxt = quat.y * quat.y;
    zz_nxt = quat.z * quat.z;
    wx_nxt = quat.w * quat.x;
    wy_nxt = quat.w * quat.y;
    wz_nxt = quat.w * quat.z;
    xy_nxt = quat.x * quat.y;
    xz_nxt = quat.x * quat.z;
    yz_nxt = quat.y * quat.z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ww_r <= ww_nxt;
      xx_r <= xx_nxt;
      yy_r <= yy_nxt;
      zz_r <= zz_nxt;
      wx_r <= wx_nxt;
      wy_r <= wy_nxt;
      wz_r <= wz_nxt;
      xy_r <= xy_nxt;
      xz_r <= xz_nxt;
      yz_r <= yz_nxt;
    end
  end

  // stage two: rotation matrix, bottom row doubles as body-frame gravity
  always_comb begin
    mat_nxt[0][0] = MW'(ww_r) + MW'(xx_r) - MW'(yy_r) - MW'(zz_r);
    mat_nxt[0][1] = (MW'(xy_r) - MW'(wz_r)) <<< 1;
    mat_nxt[0][2] = (MW'(xz_r) + MW'(wy_r)) <<< 1;
    mat_nxt[1][0] = (MW'(xy_r) + MW'(wz_r)) <<< 1;
    mat_nxt[1][1] = MW'(ww_r) - MW'(xx_r) + MW'(yy_r) - MW'(zz_r);
    mat_nxt[1][2] = (MW'(yz_r) - MW'(wx_r)) <<< 1;
    mat_nxt[2][0] = (MW'(xz_r) - MW'(wy_r)) <<< 1;
    mat_nxt[2][1] = (MW'(yz_r) + MW'(wx_r)) <<< 1;
    mat_nxt[2][2] = MW'(ww_r) - MW'(xx_r) - MW'(yy_r) + MW'(zz_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mat_r <= mat_nxt;
    end
  end

  assign mat = mat_r;

endmodule

// ----- hw/rtl/gravity_removal_world_frame_rotation_core.sv -----
// Gravity removal and world-frame rotation. Each input transfer carries a
// body-frame accelerometer sample (Q4.12 g) and an orientation quaternion
// (Q1.14); each gives exactly one output transfer with the world-frame
// linear acceleration in Q4.12, rounded half up and saturated to 16 bits.
// The quaternion is used as given, without normalization. The datapath is a
// six-stage pipeline (quaternion products, matrix sums, gravity subtraction,
// matrix-vector products, row sums, rounding and saturation); it accepts one
// sample every cycle while the output is not stalled. A stall on the output
// holds the whole pipeline in place, so in_tready follows out_tready whenever
// the output register is full.
module gravity_removal_world_frame_rotation_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // accel_x, accel_y, accel_z, quat_w, quat_x, quat_y, quat_z
  input  logic [grwf_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // world_x, world_y, world_z
  output logic [grwf_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import grwf_pkg::*;

  logic              en;
  logic [NSTG-1:0]   vld_r;
  quat_t             quat;
  field_t            acc_in [3];
  field_t            acc1_r [3];
  field_t            acc2_r [3];
  mat_t              mat2;
  mat_t              mat3_r;
  logic signed [LW-1:0] lin_r [3];
  logic signed [LW-1:0] lin_nxt [3];
  logic signed [XW-1:0] prod_r [3][3];
  logic signed [SW-1:0] sum_r [3];
  field_t            wld_r [3];
  field_t            wld_nxt [3];

  // pipeline advances whenever the output register can take a value
  assign en         = !vld_r[NSTG-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[NSTG-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  // unpack input fields
  assign acc_in[0] = in_tdata[FW-1:0];
  assign acc_in[1] = in_tdata[2*FW-1:FW];
  assign acc_in[2] = in_tdata[3*FW-1:2*FW];
  assign quat.w    = in_tdata[4*FW-1:3*FW];
  assign quat.x    = in_tdata[5*FW-1:4*FW];
  assign quat.y    = in_tdata[6*FW-1:5*FW];
  assign quat.z    = in_tdata[7*FW-1:6*FW];

  // stages one and two: quaternion to matrix
  grwf_quat_matrix u_qmat (
    .clk  (clk),
    .en   (en),
    .quat (quat),
    .mat  (mat2)
  );

  // accelerometer sample delayed to meet the matrix
  always_ff @(posedge clk) begin
    if (en) begin
      acc1_r <= acc_in;
      acc2_r <= acc1_r;
    end
  end

  // stage three: subtract rounded gravity (bottom matrix row)
  always_comb begin
    logic signed [MW-1:0] gt;
    logic signed [GW-1:0] gr;
    for (int i = 0; i < 3; i++) begin
      gt = mat2[2][i] + MW'(2048);
      gr = gt[MW-1:G_SHIFT];
      lin_nxt[i] = LW'($signed({acc2_r[i], 4'b0000})) - LW'(gr);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r  <= lin_nxt;
      mat3_r <= mat2;
    end
  end

  // stage four: matrix-vector products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= mat3_r[i][j] * lin_r[j];
        end
      end
    end
  end

  // stage five: row sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= SW'(prod_r[i][0]) + SW'(prod_r[i][1]) + SW'(prod_r[i][2]);
      end
    end
  end

  // stage six: round half up to Q4.12 and saturate
  always_comb begin
    logic signed [SW-1:0] rt;
    for (int i = 0; i < 3; i++) begin
      rt = sum_r[i] + (SW'(1) <<< (OUT_SHIFT - 1));
      wld_nxt[i] = sat_out(rt[SW-1:OUT_SHIFT]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wld_r <= wld_nxt;
    end
  end

  assign out_tdata = {wld_r[2], wld_r[1], wld_r[0]};

endmodule
